/* hdl/iou_best_region_match_core_defines.svh */
// assertion macros for the region match core
`ifndef IOU_BEST_REGION_MATCH_CORE_DEFINES_SVH
`define IOU_BEST_REGION_MATCH_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("brm check failed");

// antecedent implies consequent in the next cycle
`define BRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("brm check failed");

`endif

/* hdl/brm_pkg.sv */
package brm_pkg;

    localparam int COORD_BITS   = 16;
    localparam int STORE_BITS   = COORD_BITS + 1;
    localparam int OUT_BITS     = 17;
    localparam int IDX_BITS     = 6;
    localparam int THR_BITS     = 17;
    localparam int SCALE_BITS   = 24;
    localparam int CFG_BITS     = 24;
    localparam int CFG_IDX_BITS = 3;
    localparam int QB           = 28;
    localparam int PB           = STORE_BITS + 4;
    localparam int MW           = 29;
    localparam int PW           = 2 * MW;
    localparam int LIMB_I       = 21;
    localparam int LIMB_U       = 29;
    localparam int INTER_BITS   = 2 * LIMB_I;
    localparam int QAREA_BITS   = 2 * QB;
    localparam int UNI_BITS     = 2 * LIMB_U;
    localparam int ACCT_BITS    = THR_BITS + UNI_BITS;
    localparam int ACC_BITS     = INTER_BITS + UNI_BITS;
    localparam int STEP_BITS    = 5;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_THR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SX    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SY    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INV_X = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INV_Y = 3'd4;

    typedef struct packed {
        logic [STORE_BITS-1:0] left;
        logic [STORE_BITS-1:0] top;
        logic [STORE_BITS-1:0] right;
        logic [STORE_BITS-1:0] bottom;
    } t_region;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] ext_x;
        logic [COORD_BITS-1:0] ext_y;
    } t_box;

    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_BITS-1:0] index;
        logic [OUT_BITS-1:0] left;
        logic [OUT_BITS-1:0] top;
        logic [OUT_BITS-1:0] right;
        logic [OUT_BITS-1:0] bottom;
    } t_result;

    typedef struct packed {
        logic [THR_BITS-1:0]   thr;
        logic [SCALE_BITS-1:0] sx;
        logic [SCALE_BITS-1:0] sy;
        logic [SCALE_BITS-1:0] ivx;
        logic [SCALE_BITS-1:0] ivy;
    } t_cfg;

    typedef struct packed {
        logic rotate;
        logic done;
    } t_eval_stat;

endpackage

/* hdl/iou_best_region_match_core.sv */
// Clear and add: the result is registered when the request is accepted, unless the output
// stalls. Query: the box is scaled, each slot is scored and the best match is scaled back;
// the chain rotates once per slot and one shared multiplier scores each region.
// One request at a time; a finished result waits in a pending register while the output stalls.
// Synchronous active-low reset clears control and count and loads the default configuration.
module iou_best_region_match_core import brm_pkg::*; #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [1:0]              i_action,
    input  logic [COORD_BITS-1:0]   i_box_left,
    input  logic [COORD_BITS-1:0]   i_box_top,
    input  logic [COORD_BITS-1:0]   i_box_extent_x,
    input  logic [COORD_BITS-1:0]   i_box_extent_y,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_status,
    output logic [IDX_BITS-1:0]     o_match_index,
    output logic [OUT_BITS-1:0]     o_match_left,
    output logic [OUT_BITS-1:0]     o_match_top,
    output logic [OUT_BITS-1:0]     o_match_right,
    output logic [OUT_BITS-1:0]     o_match_bottom
);

    localparam int CW = $clog2(MAX_REGIONS + 1);

    typedef enum logic [2:0] {
        T_IDLE = 3'b001,
        T_BUSY = 3'b010,
        T_WAIT = 3'b100
    } t_tstate;

    t_tstate       r_state;
    t_cfg          r_cfg;
    logic [CW-1:0] r_count;
    logic          r_out_valid;
    t_result       r_out, r_pend;

    logic          w_accept, w_full, w_out_free, w_add, w_set;
    t_result       w_imm, eval_result;
    t_eval_stat    eval_stat;
    t_box          w_box;
    t_region       w_new;
    t_region       w_cell [MAX_REGIONS];

    assign w_accept   = i_in_valid && (r_state == T_IDLE);
    assign w_full     = r_count >= CW'(MAX_REGIONS);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_add      = w_accept && (i_action == ACT_ADD) && !w_full;
    assign w_set      = (w_accept && (i_action != ACT_QUERY) && w_out_free)
                        || ((r_state == T_BUSY) && eval_stat.done && w_out_free)
                        || ((r_state == T_WAIT) && w_out_free);

    assign w_box.left  = i_box_left;
    assign w_box.top   = i_box_top;
    assign w_box.ext_x = i_box_extent_x;
    assign w_box.ext_y = i_box_extent_y;

    assign w_new.left   = STORE_BITS'(i_box_left);
    assign w_new.top    = STORE_BITS'(i_box_top);
    assign w_new.right  = STORE_BITS'(i_box_left) + STORE_BITS'(i_box_extent_x);
    assign w_new.bottom = STORE_BITS'(i_box_top) + STORE_BITS'(i_box_extent_y);

    always_comb begin
        w_imm = '0;
        if (i_action == ACT_ADD && w_full) begin
            w_imm.status = ST_FULL;
        end
    end

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        brm_cell u_cell (
            .i_clk    (i_clk),
            .i_load   (w_add && (r_count == CW'(g))),
            .i_wdata  (w_new),
            .i_shift  (eval_stat.rotate),
            .i_next   (w_cell[(g + 1) % MAX_REGIONS]),
            .o_region (w_cell[g])
        );
    end

    brm_eval #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept && (i_action == ACT_QUERY)),
        .i_box    (w_box),
        .i_cfg    (r_cfg),
        .i_count  (r_count),
        .i_head   (w_cell[0]),
        .o_stat   (eval_stat),
        .o_result (eval_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_cfg.thr   <= THR_BITS'(32768);
            r_cfg.sx    <= SCALE_BITS'(65536);
            r_cfg.sy    <= SCALE_BITS'(65536);
            r_cfg.ivx   <= SCALE_BITS'(65536);
            r_cfg.ivy   <= SCALE_BITS'(65536);
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_THR:   r_cfg.thr <= i_cfg_data[THR_BITS-1:0];
                    CFG_SX:    r_cfg.sx  <= i_cfg_data;
                    CFG_SY:    r_cfg.sy  <= i_cfg_data;
                    CFG_INV_X: r_cfg.ivx <= i_cfg_data;
                    CFG_INV_Y: r_cfg.ivy <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_set) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        if (i_action == ACT_CLEAR) begin
                            r_count <= '0;
                        end
                        if (w_add) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_action == ACT_QUERY) begin
                            r_state <= T_BUSY;
                        end else if (w_out_free) begin
                            r_out <= w_imm;
                        end else begin
                            r_pend  <= w_imm;
                            r_state <= T_WAIT;
                        end
                    end
                end
                T_BUSY: begin
                    if (eval_stat.done) begin
                        if (w_out_free) begin
                            r_out   <= eval_result;
                            r_state <= T_IDLE;
                        end else begin
                            r_pend  <= eval_result;
                            r_state <= T_WAIT;
                        end
                    end
                end
                T_WAIT: begin
                    if (w_out_free) begin
                        r_out   <= r_pend;
                        r_state <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != T_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_match_index  = r_out.index;
    assign o_match_left   = r_out.left;
    assign o_match_top    = r_out.top;
    assign o_match_right  = r_out.right;
    assign o_match_bottom = r_out.bottom;

endmodule

/* hdl/brm_cell.sv */
module brm_cell import brm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_load,
    input  t_region i_wdata,
    input  logic    i_shift,
    input  t_region i_next,
    output t_region o_region
);

    t_region r_region;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_region <= i_wdata;
        end else if (i_shift) begin
            r_region <= i_next;
        end
    end

    assign o_region = r_region;

endmodule

/* hdl/brm_eval.sv */
module brm_eval import brm_pkg::*; #(
    parameter int MAX_REGIONS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  t_box                             i_box,
    input  t_cfg                             i_cfg,
    input  logic [$clog2(MAX_REGIONS+1)-1:0] i_count,
    input  t_region                          i_head,
    output t_eval_stat                       o_stat,
    output t_result                          o_result
);

    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    typedef enum logic [4:0] {
        E_IDLE   = 5'b00001,
        E_SCALE  = 5'b00010,
        E_REGION = 5'b00100,
        E_BACK   = 5'b01000,
        E_DONE   = 5'b10000
    } t_estate;

    t_estate                r_state;
    logic [STEP_BITS-1:0]   r_step;
    logic [IW-1:0]          r_idx;
    logic                   r_found;
    t_box                   r_box;
    logic [QB-1:0]          r_ql, r_qt, r_qr, r_qb;
    logic [QAREA_BITS-1:0]  r_qarea;
    logic [LIMB_I-1:0]      r_sx, r_sy, r_rw, r_rh;
    t_region                r_cur;
    logic [INTER_BITS-1:0]  r_inter, r_rarea, r_best_inter;
    logic [UNI_BITS-1:0]    r_uni, r_best_uni;
    logic [ACCT_BITS-1:0]   r_acc_t;
    logic [ACC_BITS-1:0]    r_acc_a, r_acc_b;
    logic [IW-1:0]          r_best_idx;
    t_region                r_best;
    logic [PW-1:0]          r_prod;
    t_result                r_result;

    logic [MW-1:0]          op_a, op_b;
    logic [PW-1:0]          n_prod;
    logic [QB-1:0]          rl_q, rt_q, rr_q, rb_q, ix0, ix1, iy0, iy1, dx, dy, qw, qh;
    logic [PB-1:0]          rl, rt, rr, rb;
    logic [LIMB_I-1:0]      w_sx, w_sy, w_rw, w_rh;
    logic                   w_skip, w_pass, w_upd, w_rot;
    logic [OUT_BITS-1:0]    w_sat;
    logic [IW+IDX_BITS-1:0] w_idx_ext;

    always_comb begin
        rl   = {i_head.left, 4'b0};
        rt   = {i_head.top, 4'b0};
        rr   = {i_head.right, 4'b0};
        rb   = {i_head.bottom, 4'b0};
        rl_q = QB'(rl);
        rt_q = QB'(rt);
        rr_q = QB'(rr);
        rb_q = QB'(rb);
        ix0  = (rl_q > r_ql) ? rl_q : r_ql;
        iy0  = (rt_q > r_qt) ? rt_q : r_qt;
        ix1  = (rr_q < r_qr) ? rr_q : r_qr;
        iy1  = (rb_q < r_qb) ? rb_q : r_qb;
        dx   = ix1 - ix0;
        dy   = iy1 - iy0;
        w_sx = (ix1 > ix0) ? dx[LIMB_I-1:0] : '0;
        w_sy = (iy1 > iy0) ? dy[LIMB_I-1:0] : '0;
        w_rw = (rr > rl) ? (rr - rl) : (rl - rr);
        w_rh = (rb > rt) ? (rb - rt) : (rt - rb);
        qw   = (r_qr > r_ql) ? (r_qr - r_ql) : (r_ql - r_qr);
        qh   = (r_qb > r_qt) ? (r_qb - r_qt) : (r_qt - r_qb);
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            E_SCALE: begin
                case (r_step)
                    5'd0: begin op_a = MW'(r_box.left);  op_b = MW'(i_cfg.sx); end
                    5'd1: begin op_a = MW'(r_box.top);   op_b = MW'(i_cfg.sy); end
                    5'd2: begin op_a = MW'(r_box.ext_x); op_b = MW'(i_cfg.sx); end
                    5'd3: begin op_a = MW'(r_box.ext_y); op_b = MW'(i_cfg.sy); end
                    5'd5: begin op_a = MW'(qw);          op_b = MW'(qh);       end
                    default: ;
                endcase
            end
            E_REGION: begin
                case (r_step)
                    5'd1:  begin op_a = MW'(r_sx); op_b = MW'(r_sy); end
                    5'd2:  begin op_a = MW'(r_rw); op_b = MW'(r_rh); end
                    5'd5:  begin op_a = MW'(i_cfg.thr); op_b = MW'(r_uni[LIMB_U-1:0]); end
                    5'd6:  begin op_a = MW'(i_cfg.thr); op_b = MW'(r_uni[UNI_BITS-1:LIMB_U]); end
                    5'd7:  begin
                        op_a = MW'(r_inter[LIMB_I-1:0]);
                        op_b = MW'(r_best_uni[LIMB_U-1:0]);
                    end
                    5'd8:  begin
                        op_a = MW'(r_inter[LIMB_I-1:0]);
                        op_b = MW'(r_best_uni[UNI_BITS-1:LIMB_U]);
                    end
                    5'd9:  begin
                        op_a = MW'(r_inter[INTER_BITS-1:LIMB_I]);
                        op_b = MW'(r_best_uni[LIMB_U-1:0]);
                    end
                    5'd10: begin
                        op_a = MW'(r_inter[INTER_BITS-1:LIMB_I]);
                        op_b = MW'(r_best_uni[UNI_BITS-1:LIMB_U]);
                    end
                    5'd11: begin
                        op_a = MW'(r_best_inter[LIMB_I-1:0]);
                        op_b = MW'(r_uni[LIMB_U-1:0]);
                    end
                    5'd12: begin
                        op_a = MW'(r_best_inter[LIMB_I-1:0]);
                        op_b = MW'(r_uni[UNI_BITS-1:LIMB_U]);
                    end
                    5'd13: begin
                        op_a = MW'(r_best_inter[INTER_BITS-1:LIMB_I]);
                        op_b = MW'(r_uni[LIMB_U-1:0]);
                    end
                    5'd14: begin
                        op_a = MW'(r_best_inter[INTER_BITS-1:LIMB_I]);
                        op_b = MW'(r_uni[UNI_BITS-1:LIMB_U]);
                    end
                    default: ;
                endcase
            end
            E_BACK: begin
                case (r_step)
                    5'd0: begin op_a = MW'(r_best.left);   op_b = MW'(i_cfg.ivx); end
                    5'd1: begin op_a = MW'(r_best.top);    op_b = MW'(i_cfg.ivy); end
                    5'd2: begin op_a = MW'(r_best.right);  op_b = MW'(i_cfg.ivx); end
                    5'd3: begin op_a = MW'(r_best.bottom); op_b = MW'(i_cfg.ivy); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign n_prod    = op_a * op_b;
    assign w_skip    = CW'(r_idx) >= i_count;
    assign w_rot     = (r_step == 5'd0 && w_skip) || r_step == 5'd16;
    assign w_pass    = (r_uni != '0) && (ACCT_BITS'({r_inter, 16'h0}) >= r_acc_t);
    assign w_upd     = w_pass && (!r_found || (r_acc_a > r_acc_b));
    assign w_sat     = (|r_prod[PW-1:OUT_BITS+16]) ? '1 : r_prod[OUT_BITS+15:16];
    assign w_idx_ext = (IW+IDX_BITS)'(r_best_idx);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            case (r_state)
                E_IDLE: begin
                    if (i_start) begin
                        r_box   <= i_box;
                        r_found <= 1'b0;
                        r_step  <= '0;
                        r_state <= E_SCALE;
                    end
                end
                E_SCALE: begin
                    r_step <= (r_step == 5'd6) ? '0 : r_step + 5'd1;
                    case (r_step)
                        5'd1: r_ql <= r_prod[QB+11:12];
                        5'd2: r_qt <= r_prod[QB+11:12];
                        5'd3: r_qr <= r_prod[QB+11:12];
                        5'd4: r_qb <= r_prod[QB+11:12];
                        5'd6: begin
                            r_qarea <= r_prod[QAREA_BITS-1:0];
                            r_idx   <= '0;
                            r_state <= E_REGION;
                        end
                        default: ;
                    endcase
                end
                E_REGION: begin
                    r_step <= w_rot ? '0 : r_step + 5'd1;
                    case (r_step)
                        5'd0: begin
                            r_cur <= i_head;
                            r_sx  <= w_sx;
                            r_sy  <= w_sy;
                            r_rw  <= w_rw;
                            r_rh  <= w_rh;
                        end
                        5'd2:  r_inter <= r_prod[INTER_BITS-1:0];
                        5'd3:  r_rarea <= r_prod[INTER_BITS-1:0];
                        5'd4:  r_uni <= UNI_BITS'(r_rarea) + UNI_BITS'(r_qarea)
                                        - UNI_BITS'(r_inter);
                        5'd6:  r_acc_t <= ACCT_BITS'(r_prod);
                        5'd7:  r_acc_t <= r_acc_t + (ACCT_BITS'(r_prod) << 29);
                        5'd8:  r_acc_a <= ACC_BITS'(r_prod);
                        5'd9:  r_acc_a <= r_acc_a + (ACC_BITS'(r_prod) << 29);
                        5'd10: r_acc_a <= r_acc_a + (ACC_BITS'(r_prod) << 21);
                        5'd11: r_acc_a <= r_acc_a + (ACC_BITS'(r_prod) << 50);
                        5'd12: r_acc_b <= ACC_BITS'(r_prod);
                        5'd13: r_acc_b <= r_acc_b + (ACC_BITS'(r_prod) << 29);
                        5'd14: r_acc_b <= r_acc_b + (ACC_BITS'(r_prod) << 21);
                        5'd15: r_acc_b <= r_acc_b + (ACC_BITS'(r_prod) << 50);
                        5'd16: begin
                            if (w_upd) begin
                                r_found      <= 1'b1;
                                r_best_idx   <= r_idx;
                                r_best_inter <= r_inter;
                                r_best_uni   <= r_uni;
                                r_best       <= r_cur;
                            end
                        end
                        default: ;
                    endcase
                    if (w_rot) begin
                        if (r_idx == IW'(MAX_REGIONS - 1)) begin
                            r_state <= E_BACK;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                E_BACK: begin
                    r_step <= r_step + 5'd1;
                    case (r_step)
                        5'd0: begin
                            if (!r_found) begin
                                r_result <= {ST_NOMATCH, (IDX_BITS + 4 * OUT_BITS)'(0)};
                                r_state  <= E_DONE;
                            end else begin
                                r_result.status <= ST_OK;
                                r_result.index  <= w_idx_ext[IDX_BITS-1:0];
                            end
                        end
                        5'd1: r_result.left  <= w_sat;
                        5'd2: r_result.top   <= w_sat;
                        5'd3: r_result.right <= w_sat;
                        5'd4: begin
                            r_result.bottom <= w_sat;
                            r_state         <= E_DONE;
                        end
                        default: ;
                    endcase
                end
                E_DONE: r_state <= E_IDLE;
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_stat.rotate = (r_state == E_REGION) && w_rot;
    assign o_stat.done   = (r_state == E_DONE);
    assign o_result      = r_result;

endmodule

/* hdl/brm_checker.sv */
`include "iou_best_region_match_core_defines.svh"

module brm_checker import brm_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic [1:0]              i_action,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [1:0]              o_status,
    input logic [IDX_BITS-1:0]     o_match_index,
    input logic [OUT_BITS-1:0]     o_match_left,
    input logic [OUT_BITS-1:0]     o_match_top,
    input logic [OUT_BITS-1:0]     o_match_right,
    input logic [OUT_BITS-1:0]     o_match_bottom
);

    `BRM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    `BRM_ASSERT_NOW(a_nomatch_zero, o_out_valid && (o_status != ST_OK), o_match_index == '0 && o_match_left == '0 && o_match_top == '0 && o_match_right == '0 && o_match_bottom == '0)

    `BRM_ASSERT_NOW(a_status_code, o_out_valid, o_status == ST_OK || o_status == ST_FULL || o_status == ST_NOMATCH)

    `BRM_ASSERT_NEXT(a_query_stall, i_in_valid && !o_in_stall && i_action == ACT_QUERY, o_in_stall)

endmodule

bind iou_best_region_match_core brm_checker u_brm_checker (.*);
